FILE: rtl/core/cau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operation codes, item and result records, saturation and angle tables.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int ITER_STAGES      = 32;  // one root bit per stage
  localparam int CW               = 35;  // CORDIC x/y width

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_CONJ = 3'd3;
  localparam logic [2:0] OP_MAG  = 3'd4;
  localparam logic [2:0] OP_ARG  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  localparam logic signed [65:0] I32_MAX66 = 66'sh7FFFFFFF;
  localparam logic signed [65:0] I32_MIN66 = -66'sh80000000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    CL_ADD, CL_SUB, CL_MUL, CL_CONJ, CL_MAG, CL_ARG, CL_NONE
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] ar;
    logic [31:0] ai;
    logic [31:0] br;
    logic [31:0] bi;
  } item_t;

  typedef struct packed {
    logic [31:0] rr;
    logic [31:0] ri;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic          v;
    cls_t          cls;
    logic [31:0]   rr;
    logic [31:0]   ri;
    logic          sat;
    logic          zb;    // both parts zero
    logic          zr;    // real part zero
    logic          ain;   // imaginary part negative
    logic [63:0]   rad;
    logic [34:0]   rem;
    logic [31:0]   root;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0]   z;
  } pipe_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    r.hit = 1'b0;
    r.val = v[31:0];
    if (v > I32_MAX66) begin
      r.hit = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < I32_MIN66) begin
      r.hit = 1'b1;
      r.val = 32'h8000_0000;
    end
    return r;
  endfunction

  function automatic logic [63:0] atan_q30(input int k);
    logic [63:0] q;
    case (k)
      0:  q = 64'd843314857;
      1:  q = 64'd497837829;
      2:  q = 64'd263043837;
      3:  q = 64'd133525159;
      4:  q = 64'd67021687;
      5:  q = 64'd33543516;
      6:  q = 64'd16775851;
      7:  q = 64'd8388437;
      8:  q = 64'd4194283;
      9:  q = 64'd2097149;
      10: q = 64'd1048576;
      11: q = 64'd524288;
      12: q = 64'd262144;
      13: q = 64'd131072;
      14: q = 64'd65536;
      15: q = 64'd32768;
      16: q = 64'd16384;
      17: q = 64'd8192;
      18: q = 64'd4096;
      19: q = 64'd2048;
      20: q = 64'd1024;
      21: q = 64'd512;
      22: q = 64'd256;
      23: q = 64'd128;
      default: q = 64'd0;
    endcase
    return q;
  endfunction

  // round a Q30 angle to nearest with f fraction bits
  function automatic logic [31:0] to_frac(input logic [63:0] q30, input int f);
    logic [63:0] r;
    r = (q30 + (64'd1 << (30 - f - 1))) >> (30 - f);
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cau_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_fifo: small register queue
// First-in first-out storage with full/empty flags and a show-ahead read.
// ----------------------------------------------------------------------------
module cau_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/cau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front: request intake
// Classify each request, route multiplier operands, and queue it.
// ----------------------------------------------------------------------------
module cau_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_a_real,
  input  wire logic [31:0] in_a_imag,
  input  wire logic [31:0] in_b_real,
  input  wire logic [31:0] in_b_imag,
  input  wire logic        q_pop,
  output logic             q_empty,
  output cau_pkg::item_t   q_item
);
  import cau_pkg::*;

  item_t it;

  always_comb begin
    it.ar = in_a_real;
    it.ai = in_a_imag;
    it.br = in_b_real;
    it.bi = in_b_imag;
    case (in_operation)
      OP_ADD:  it.cls = CL_ADD;
      OP_SUB:  it.cls = CL_SUB;
      OP_MUL:  it.cls = CL_MUL;
      OP_CONJ: it.cls = CL_CONJ;
      OP_MAG: begin
        // square a on the shared multipliers
        it.cls = CL_MAG;
        it.br  = in_a_real;
        it.bi  = in_a_imag;
      end
      OP_ARG:  it.cls = CL_ARG;
      default: it.cls = CL_NONE;
    endcase
  end

  cau_fifo #(.W($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (it),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );
endmodule
`default_nettype wire

FILE: rtl/core/cau_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back: execution pipeline
// Multiply stage, combine stage, then a chain of root/CORDIC steps.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire cau_pkg::item_t q_item,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               res_v,
  output cau_pkg::res_t      res
);
  import cau_pkg::*;

  localparam logic [31:0] LIM = to_frac(HALF_PI_Q30, FRAC_BITS);

  // multiply stage
  logic               s1_v_r;
  cls_t               s1_cls_r;
  logic signed [31:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cls_r <= q_item.cls;
      s1_ar_r  <= $signed(q_item.ar);
      s1_ai_r  <= $signed(q_item.ai);
      s1_br_r  <= $signed(q_item.br);
      s1_bi_r  <= $signed(q_item.bi);
      p_rr_r   <= $signed(q_item.ar) * $signed(q_item.br);
      p_ii_r   <= $signed(q_item.ai) * $signed(q_item.bi);
      p_ri_r   <= $signed(q_item.ar) * $signed(q_item.bi);
      p_ir_r   <= $signed(q_item.ai) * $signed(q_item.br);
    end
  end

  // combine stage
  pipe_t             p0;
  sat_t              sa, sb;
  logic signed [65:0] re66, im66;

  always_comb begin
    re66 = (66'(p_rr_r) - 66'(p_ii_r)) >>> FRAC_BITS;
    im66 = (66'(p_ri_r) + 66'(p_ir_r)) >>> FRAC_BITS;
    sa   = '0;
    sb   = '0;
    case (s1_cls_r)
      CL_ADD: begin
        sa = sat32(66'(s1_ar_r) + 66'(s1_br_r));
        sb = sat32(66'(s1_ai_r) + 66'(s1_bi_r));
      end
      CL_SUB: begin
        sa = sat32(66'(s1_ar_r) - 66'(s1_br_r));
        sb = sat32(66'(s1_ai_r) - 66'(s1_bi_r));
      end
      CL_MUL: begin
        sa = sat32(re66);
        sb = sat32(im66);
      end
      CL_CONJ: begin
        sa.val = s1_ar_r;
        sb     = sat32(-66'(s1_ai_r));
      end
      default: begin
        sa = '0;
        sb = '0;
      end
    endcase
    p0.v    = s1_v_r;
    p0.cls  = s1_cls_r;
    p0.rr   = sa.val;
    p0.ri   = sb.val;
    p0.sat  = sa.hit || sb.hit;
    p0.zb   = (s1_ar_r == '0) && (s1_ai_r == '0);
    p0.zr   = (s1_ar_r == '0);
    p0.ain  = s1_ai_r[31];
    p0.rad  = p_rr_r + p_ii_r;
    p0.rem  = '0;
    p0.root = '0;
    // fold the left half plane onto the right one
    p0.x    = s1_ar_r[31] ? -CW'(s1_ar_r) : CW'(s1_ar_r);
    p0.y    = s1_ar_r[31] ? -CW'(s1_ai_r) : CW'(s1_ai_r);
    p0.z    = '0;
  end

  pipe_t pipe_r [ITER_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r[0].v <= 1'b0;
    end else if (adv) begin
      pipe_r[0].v <= p0.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0].cls  <= p0.cls;
      pipe_r[0].rr   <= p0.rr;
      pipe_r[0].ri   <= p0.ri;
      pipe_r[0].sat  <= p0.sat;
      pipe_r[0].zb   <= p0.zb;
      pipe_r[0].zr   <= p0.zr;
      pipe_r[0].ain  <= p0.ain;
      pipe_r[0].rad  <= p0.rad;
      pipe_r[0].rem  <= p0.rem;
      pipe_r[0].root <= p0.root;
      pipe_r[0].x    <= p0.x;
      pipe_r[0].y    <= p0.y;
      pipe_r[0].z    <= p0.z;
    end
  end

  // one root bit per stage, and one rotation in each of the first CORDIC_STEPS stages
  for (genvar k = 0; k < ITER_STAGES; k++) begin : g_it
    pipe_t      nx;
    logic [34:0] rt, tr;

    always_comb begin
      nx      = pipe_r[k];
      rt      = {pipe_r[k].rem[32:0], pipe_r[k].rad[63:62]};
      tr      = {1'b0, pipe_r[k].root, 2'b01};
      nx.rad  = {pipe_r[k].rad[61:0], 2'b00};
      if (rt >= tr) begin
        nx.rem  = rt - tr;
        nx.root = {pipe_r[k].root[30:0], 1'b1};
      end else begin
        nx.rem  = rt;
        nx.root = {pipe_r[k].root[30:0], 1'b0};
      end
      if (k < CORDIC_STEPS) begin
        if (!pipe_r[k].y[CW-1]) begin
          nx.x = pipe_r[k].x + CW'($signed(pipe_r[k].y) >>> k);
          nx.y = pipe_r[k].y - CW'($signed(pipe_r[k].x) >>> k);
          nx.z = pipe_r[k].z + to_frac(atan_q30(k), FRAC_BITS);
        end else begin
          nx.x = pipe_r[k].x - CW'($signed(pipe_r[k].y) >>> k);
          nx.y = pipe_r[k].y + CW'($signed(pipe_r[k].x) >>> k);
          nx.z = pipe_r[k].z - to_frac(atan_q30(k), FRAC_BITS);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[k+1].v <= 1'b0;
      end else if (adv) begin
        pipe_r[k+1].v <= nx.v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[k+1].cls  <= nx.cls;
        pipe_r[k+1].rr   <= nx.rr;
        pipe_r[k+1].ri   <= nx.ri;
        pipe_r[k+1].sat  <= nx.sat;
        pipe_r[k+1].zb   <= nx.zb;
        pipe_r[k+1].zr   <= nx.zr;
        pipe_r[k+1].ain  <= nx.ain;
        pipe_r[k+1].rad  <= nx.rad;
        pipe_r[k+1].rem  <= nx.rem;
        pipe_r[k+1].root <= nx.root;
        pipe_r[k+1].x    <= nx.x;
        pipe_r[k+1].y    <= nx.y;
        pipe_r[k+1].z    <= nx.z;
      end
    end
  end

  // result select
  pipe_t pl;
  assign pl    = pipe_r[ITER_STAGES];
  assign res_v = pl.v;

  always_comb begin
    res.rr     = pl.rr;
    res.ri     = pl.ri;
    res.status = pl.sat ? ST_SAT : ST_OK;
    case (pl.cls)
      CL_MAG: begin
        res.ri = '0;
        if (pl.root[31]) begin
          res.rr     = 32'h7FFF_FFFF;
          res.status = ST_SAT;
        end else begin
          res.rr     = pl.root;
          res.status = ST_OK;
        end
      end
      CL_ARG: begin
        res.ri     = '0;
        res.status = ST_OK;
        if (pl.zb) begin
          res.rr     = '0;
          res.status = ST_UNDEF;
        end else if (pl.zr) begin
          res.rr = pl.ain ? -LIM : LIM;
        end else if ($signed(pl.z) > $signed(LIM)) begin
          res.rr = LIM;
        end else if ($signed(pl.z) < -$signed(LIM)) begin
          res.rr = -LIM;
        end else begin
          res.rr = pl.z;
        end
      end
      default: begin
        res.rr = pl.rr;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: fixed-point complex ALU
// Add, subtract, multiply, conjugate, magnitude and argument of Q-format
// complex operands, with saturation and status flags.
// ----------------------------------------------------------------------------
// One request per cycle is accepted and one result per cycle is delivered,
// in request order, unless a full queue stalls the flow. Between the intake
// and result queues a request passes the execution pipeline (multiply,
// combine, then 32 steps that each form one bit of the square root and,
// in the first CORDIC_STEPS of them, one CORDIC rotation). The 32-step
// root chain sets the pipeline's length. Both sides are queues: push while
// full is low, pop while empty is low. When the result queue fills, the
// pipeline holds; the intake queue takes requests until it too is full.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_a_real,
  input  wire logic [31:0] in_a_imag,
  input  wire logic [31:0] in_b_real,
  input  wire logic [31:0] in_b_imag,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_res_real,
  output logic [31:0]      out_res_imag,
  output logic [1:0]       out_status
);
  import cau_pkg::*;

  item_t q_item;
  logic  q_empty, q_pop;
  logic  adv, res_v, rq_full;
  res_t  res, rq_out;

  // intake: classify and queue
  cau_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_a_real    (in_a_real),
    .in_a_imag    (in_a_imag),
    .in_b_real    (in_b_real),
    .in_b_imag    (in_b_imag),
    .q_pop        (q_pop),
    .q_empty      (q_empty),
    .q_item       (q_item)
  );

  // advance the pipeline whenever the result queue can take its last stage
  assign adv = !rq_full;

  cau_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res_v   (res_v),
    .res     (res)
  );

  // result queue decouples the pipeline from the consumer
  cau_fifo #(.W($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_rq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (adv && res_v),
    .wdata (res),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_out),
    .empty (empty)
  );

  assign out_res_real = rq_out.rr;
  assign out_res_imag = rq_out.ri;
  assign out_status   = rq_out.status;

  // an undefined argument carries a zero value
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_UNDEF) |-> (out_res_real == '0 && out_res_imag == '0))
    else $error("undefined argument with nonzero value");

  // the status code never takes the unused value
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == ST_OK || out_status == ST_SAT || out_status == ST_UNDEF))
    else $error("bad status code");

  // a held pipeline means the result queue is full
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (rq_full && !empty))
    else $error("pipeline held without a full result queue");
endmodule
`default_nettype wire
